>>> hw/rtl/ccte_pkg.sv
// Shared types and constants for the cluster chain table engine.
// Used by ccte_ctrl, ccte_dpath and cluster_chain_table_engine_unit; no dependencies.
`default_nettype none

package ccte_pkg;

    // Field widths of the transfer payloads.
    localparam int CW  = 7;
    localparam int OPW = 3;
    localparam int HW  = 8;
    localparam int STW = 2;

    // Largest table the link store can hold.
    localparam int MAX_CLUSTERS = 128;

    // Operation codes.
    localparam logic [OPW-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OPW-1:0] OP_ALLOC  = 3'd1;
    localparam logic [OPW-1:0] OP_NEXT   = 3'd2;
    localparam logic [OPW-1:0] OP_HOP    = 3'd3;
    localparam logic [OPW-1:0] OP_FREE   = 3'd4;
    localparam logic [OPW-1:0] OP_UNLINK = 3'd5;
    localparam logic [OPW-1:0] OP_COUNT  = 3'd6;

    // Status codes.
    localparam logic [STW-1:0] ST_OK       = 2'd0;
    localparam logic [STW-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STW-1:0] ST_NOT_USED = 2'd2;

    typedef struct packed {
        logic [OPW-1:0] opcode;
        logic [CW-1:0]  cluster;
        logic [HW-1:0]  hops;
    } t_in_item;

    typedef struct packed {
        logic [CW-1:0]  result_cluster;
        logic [STW-1:0] status;
        logic [CW-1:0]  free_count;
    } t_out_item;

    // Datapath micro-operations, one per cycle.
    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LOAD,
        DP_CLEAR,
        DP_RD_CUR,
        DP_SCAN_INIT,
        DP_SCAN,
        DP_STEP,
        DP_EXT_LINK,
        DP_EXT_SELF,
        DP_ALLOC_W,
        DP_FAIL_FULL,
        DP_FAIL_UNUSED,
        DP_RES_CUR,
        DP_FREE_STEP,
        DP_UL_LATCH,
        DP_UL_CLEAR,
        DP_OUT
    } t_dp_op;

    // What a table scan does with each entry it reads.
    typedef enum logic [1:0] {
        SCAN_FIND,
        SCAN_COUNT,
        SCAN_UNLINK
    } t_scan_mode;

    typedef struct packed {
        t_dp_op     op;
        t_scan_mode mode;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPW-1:0] opcode;
        logic           hops_zero;
        logic           cur_in_range;
        logic           cur_zero;
        logic           rd_is_cur;
        logic           rd_is_zero;
        logic           scan_hit;
        logic           scan_done;
        logic           walk_done;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/ccte_dpath.sv
// Datapath of the cluster chain table engine: link memory, valid bits,
// scan pipeline, working registers and the result register. Uses ccte_pkg.
`default_nettype none

module ccte_dpath #(
    parameter int NUM_CLUSTERS = 128
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ccte_pkg::t_dp_cmd   i_cmd,
    input  ccte_pkg::t_in_item  i_item,
    output ccte_pkg::t_dp_stat  o_stat,
    output ccte_pkg::t_out_item o_item
);

    localparam int TBL = (NUM_CLUSTERS < ccte_pkg::MAX_CLUSTERS) ?
                         NUM_CLUSTERS : ccte_pkg::MAX_CLUSTERS;
    localparam int AW  = $clog2(TBL);
    localparam int CW  = ccte_pkg::CW;
    localparam int HW  = ccte_pkg::HW;
    localparam logic [AW:0] TBL_END = (AW+1)'(TBL);

    // Link store and its valid bits; an entry that is not valid reads as free.
    logic [CW-1:0] r_mem [TBL];
    logic [TBL-1:0] r_vld;
    logic [CW-1:0] r_rdata;
    logic          r_rd_vld;
    logic          r_roor;

    // Working registers.
    logic [ccte_pkg::OPW-1:0] r_op;
    logic [CW-1:0]            r_cur;
    logic [CW-1:0]            r_nx;
    logic [AW-1:0]            r_free;
    logic [CW-1:0]            r_res;
    logic [ccte_pkg::STW-1:0] r_st;
    logic [CW-1:0]            r_cnt;
    logic [HW-1:0]            r_hops;
    logic [AW:0]              r_walk;
    logic [AW:0]              r_sidx;
    logic [AW-1:0]            r_pidx;
    logic                     r_pv;
    ccte_pkg::t_scan_mode     r_mode;
    ccte_pkg::t_out_item      r_out;

    logic          cur_in_range;
    logic [AW-1:0] cur_idx;
    logic [CW-1:0] rd_val;
    logic          rd_is_cur;
    logic          rd_is_zero;
    logic          scan_issue;
    logic          scan_hit;
    logic          ul_match;
    logic [AW-1:0] rd_idx;
    logic          wr_en;
    logic [AW-1:0] wr_idx;
    logic [CW-1:0] wr_data;

    // Read value and the compares the controller branches on.
    assign cur_in_range = ({1'b0, r_cur} < (CW+1)'(TBL));
    assign cur_idx      = r_cur[AW-1:0];
    assign rd_val       = (r_rd_vld && !r_roor) ? r_rdata : '0;
    assign rd_is_cur    = (rd_val == r_cur);
    assign rd_is_zero   = (rd_val == '0);
    assign scan_issue   = (i_cmd.op == ccte_pkg::DP_SCAN) && (r_sidx < TBL_END);
    assign scan_hit     = r_pv && rd_is_zero && (r_mode == ccte_pkg::SCAN_FIND);
    assign ul_match     = (i_cmd.op == ccte_pkg::DP_SCAN) && r_pv &&
                          (r_mode == ccte_pkg::SCAN_UNLINK) && (rd_val == r_cur);
    assign rd_idx       = (i_cmd.op == ccte_pkg::DP_SCAN) ? r_sidx[AW-1:0] : cur_idx;

    // Status toward the controller.
    always_comb begin
        o_stat.opcode       = r_op;
        o_stat.hops_zero    = (r_hops == '0);
        o_stat.cur_in_range = cur_in_range;
        o_stat.cur_zero     = (r_cur == '0);
        o_stat.rd_is_cur    = rd_is_cur;
        o_stat.rd_is_zero   = rd_is_zero;
        o_stat.scan_hit     = scan_hit;
        o_stat.scan_done    = (r_sidx == TBL_END) && !r_pv;
        o_stat.walk_done    = (r_walk == TBL_END);
    end

    // Write port selection.
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = cur_idx;
        wr_data = '0;
        unique case (i_cmd.op)
            ccte_pkg::DP_EXT_LINK: begin
                wr_en   = 1'b1;
                wr_data = CW'(r_free);
            end
            ccte_pkg::DP_EXT_SELF, ccte_pkg::DP_ALLOC_W: begin
                wr_en   = 1'b1;
                wr_idx  = r_free;
                wr_data = CW'(r_free);
            end
            ccte_pkg::DP_FREE_STEP, ccte_pkg::DP_UL_CLEAR: begin
                wr_en = cur_in_range;
            end
            ccte_pkg::DP_SCAN: begin
                // A predecessor of the unlinked cluster skips over it, or ends
                // its chain when the unlinked cluster was the last one.
                wr_en   = ul_match;
                wr_idx  = r_pidx;
                wr_data = (r_nx == r_cur) ? CW'(r_pidx) : r_nx;
            end
            default: begin
            end
        endcase
    end

    // Link memory with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        r_rdata <= r_mem[rd_idx];
    end

    // Valid bits; clearing the table drops them all at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_roor   <= 1'b0;
        end else begin
            if (i_cmd.op == ccte_pkg::DP_CLEAR) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[rd_idx];
            r_roor   <= (i_cmd.op == ccte_pkg::DP_RD_CUR) && !cur_in_range;
        end
    end

    // Working registers, updated by the current micro-operation.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ccte_pkg::DP_LOAD: begin
                r_op   <= i_item.opcode;
                r_cur  <= i_item.cluster;
                r_hops <= (i_item.opcode == ccte_pkg::OP_NEXT) ? HW'(1) : i_item.hops;
                r_res  <= '0;
                r_st   <= ccte_pkg::ST_OK;
                r_cnt  <= '0;
                r_walk <= '0;
            end
            ccte_pkg::DP_SCAN_INIT: begin
                r_mode <= i_cmd.mode;
                r_sidx <= (AW+1)'(1);
                r_pv   <= 1'b0;
            end
            ccte_pkg::DP_UL_LATCH: begin
                r_nx   <= rd_val;
                r_mode <= ccte_pkg::SCAN_UNLINK;
                r_sidx <= '0;
                r_pv   <= 1'b0;
            end
            ccte_pkg::DP_SCAN: begin
                if (scan_issue) begin
                    r_sidx <= r_sidx + (AW+1)'(1);
                end
                r_pv   <= scan_issue;
                r_pidx <= r_sidx[AW-1:0];
                if (scan_hit) begin
                    r_free <= r_pidx;
                end
                if (r_pv && rd_is_zero && (r_mode == ccte_pkg::SCAN_COUNT)) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            ccte_pkg::DP_STEP: begin
                r_cur  <= rd_val;
                r_hops <= r_hops - HW'(1);
            end
            ccte_pkg::DP_EXT_SELF: begin
                r_cur  <= CW'(r_free);
                r_hops <= r_hops - HW'(1);
            end
            ccte_pkg::DP_ALLOC_W: begin
                r_res <= CW'(r_free);
            end
            ccte_pkg::DP_FAIL_FULL: begin
                r_res <= '0;
                r_st  <= ccte_pkg::ST_NO_FREE;
            end
            ccte_pkg::DP_FAIL_UNUSED: begin
                r_res <= '0;
                r_st  <= ccte_pkg::ST_NOT_USED;
            end
            ccte_pkg::DP_RES_CUR: begin
                r_res <= r_cur;
            end
            ccte_pkg::DP_FREE_STEP: begin
                r_cur  <= rd_is_cur ? '0 : rd_val;
                r_walk <= r_walk + (AW+1)'(1);
            end
            ccte_pkg::DP_OUT: begin
                r_out.result_cluster <= r_res;
                r_out.status         <= r_st;
                r_out.free_count     <= r_cnt;
            end
            default: begin
            end
        endcase
    end

    assign o_item = r_out;

    // Clearing the table leaves no entry marked as written.
    a_clear_drops_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ccte_pkg::DP_CLEAR) |=> (r_vld == '0))
        else $error("valid bits survived a table clear");

    // An unlink scan never writes the entry it is reading in the same cycle.
    a_scan_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == ccte_pkg::DP_SCAN) && wr_en) |-> (wr_idx != rd_idx))
        else $error("scan write hit the entry being read");

    // The reserved cluster is never handed out.
    a_no_reserved_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == ccte_pkg::DP_ALLOC_W) || (i_cmd.op == ccte_pkg::DP_EXT_SELF))
        |-> (r_free != '0))
        else $error("cluster zero allocated");

endmodule

`default_nettype wire

>>> hw/rtl/ccte_ctrl.sv
// Controller of the cluster chain table engine: sequences the datapath for
// each operation and owns both channel handshakes. Uses ccte_pkg.
`default_nettype none

module ccte_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    input  ccte_pkg::t_dp_stat i_stat,
    output ccte_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_AL_SCAN,
        S_AL_WRITE,
        S_STEP_CHK,
        S_STEP_RD,
        S_EXT_SCAN,
        S_EXT_LINK,
        S_EXT_SELF,
        S_FW_CHK,
        S_FW_RD,
        S_UL_RD,
        S_UL_SCAN,
        S_CNT_SCAN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   in_xfer;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Next state and the micro-operation for this cycle.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = ccte_pkg::DP_IDLE;
        o_cmd.mode = ccte_pkg::SCAN_FIND;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.op = ccte_pkg::DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.opcode)
                    ccte_pkg::OP_CLEAR: begin
                        o_cmd.op = ccte_pkg::DP_CLEAR;
                        n_state  = S_FIN;
                    end
                    ccte_pkg::OP_ALLOC: begin
                        o_cmd.op = ccte_pkg::DP_SCAN_INIT;
                        n_state  = S_AL_SCAN;
                    end
                    ccte_pkg::OP_NEXT, ccte_pkg::OP_HOP: begin
                        n_state = S_STEP_CHK;
                    end
                    ccte_pkg::OP_FREE: begin
                        n_state = S_FW_CHK;
                    end
                    ccte_pkg::OP_UNLINK: begin
                        o_cmd.op = ccte_pkg::DP_RD_CUR;
                        n_state  = S_UL_RD;
                    end
                    ccte_pkg::OP_COUNT: begin
                        o_cmd.op   = ccte_pkg::DP_SCAN_INIT;
                        o_cmd.mode = ccte_pkg::SCAN_COUNT;
                        n_state    = S_CNT_SCAN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_AL_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.op = ccte_pkg::DP_FAIL_FULL;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = ccte_pkg::DP_SCAN;
                    if (i_stat.scan_hit) begin
                        n_state = S_AL_WRITE;
                    end
                end
            end
            S_AL_WRITE: begin
                o_cmd.op = ccte_pkg::DP_ALLOC_W;
                n_state  = S_FIN;
            end
            S_STEP_CHK: begin
                priority if (i_stat.hops_zero) begin
                    o_cmd.op = ccte_pkg::DP_RES_CUR;
                    n_state  = S_FIN;
                end else if (!i_stat.cur_in_range) begin
                    o_cmd.op = ccte_pkg::DP_FAIL_UNUSED;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = ccte_pkg::DP_RD_CUR;
                    n_state  = S_STEP_RD;
                end
            end
            S_STEP_RD: begin
                // A self link ends the chain, so the chain is extended.
                priority if (i_stat.rd_is_cur) begin
                    o_cmd.op = ccte_pkg::DP_SCAN_INIT;
                    n_state  = S_EXT_SCAN;
                end else if (i_stat.rd_is_zero) begin
                    o_cmd.op = ccte_pkg::DP_FAIL_UNUSED;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = ccte_pkg::DP_STEP;
                    n_state  = S_STEP_CHK;
                end
            end
            S_EXT_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.op = ccte_pkg::DP_FAIL_FULL;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = ccte_pkg::DP_SCAN;
                    if (i_stat.scan_hit) begin
                        n_state = S_EXT_LINK;
                    end
                end
            end
            S_EXT_LINK: begin
                o_cmd.op = ccte_pkg::DP_EXT_LINK;
                n_state  = S_EXT_SELF;
            end
            S_EXT_SELF: begin
                o_cmd.op = ccte_pkg::DP_EXT_SELF;
                n_state  = S_STEP_CHK;
            end
            S_FW_CHK: begin
                if (i_stat.cur_zero || i_stat.walk_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = ccte_pkg::DP_RD_CUR;
                    n_state  = S_FW_RD;
                end
            end
            S_FW_RD: begin
                o_cmd.op = ccte_pkg::DP_FREE_STEP;
                n_state  = S_FW_CHK;
            end
            S_UL_RD: begin
                if (i_stat.rd_is_zero) begin
                    o_cmd.op = ccte_pkg::DP_FAIL_UNUSED;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = ccte_pkg::DP_UL_LATCH;
                    n_state  = S_UL_SCAN;
                end
            end
            S_UL_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.op = ccte_pkg::DP_UL_CLEAR;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op   = ccte_pkg::DP_SCAN;
                    o_cmd.mode = ccte_pkg::SCAN_UNLINK;
                end
            end
            S_CNT_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op   = ccte_pkg::DP_SCAN;
                    o_cmd.mode = ccte_pkg::SCAN_COUNT;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.op = ccte_pkg::DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == ccte_pkg::DP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // An accepted item always goes to opcode dispatch.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_DISPATCH))
        else $error("accepted item did not reach dispatch");

    // Loading a result frees the input side and shows the result.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ccte_pkg::DP_OUT) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("result load did not complete");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ccte_pkg::DP_OUT) |-> !(r_out_valid && i_out_stall))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

>>> hw/rtl/cluster_chain_table_engine_unit.sv
// Top level of the cluster chain table engine: a link table of next-cluster
// entries with clear, allocate, walk, free, unlink and count. Uses ccte_pkg,
// ccte_ctrl and ccte_dpath.
//
// Channel  Direction  Handshake                    Payload
// in       input      i_in_valid / o_in_stall      i_in_item  (opcode, cluster, hops)
// out      output     o_out_valid / i_out_stall    o_out_item (result_cluster, status,
//                                                             free_count)
//
// One item at a time; T = min(NUM_CLUSTERS, 128) table entries, one memory read per cycle.
// Allocate and count scan the table, one entry scanned a cycle.
// Next/hop read each link followed; a self link at a chain's end is extended by a table scan.
// Free chain reads and clears each freed link; unlink scans the table for predecessors.
// Reset empties the table at once through per-entry valid bits, no clearing pass.
// A result waits in the output register under stall while the next item is taken.
`default_nettype none

module cluster_chain_table_engine_unit #(
    parameter int NUM_CLUSTERS = 128
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  ccte_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ccte_pkg::t_out_item o_out_item
);

    ccte_pkg::t_dp_cmd  cmd;
    ccte_pkg::t_dp_stat stat;

    // Sequencer.
    ccte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Table storage and working registers.
    ccte_dpath #(
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_item),
        .o_stat  (stat),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> tb/cluster_chain_table_engine_unit_tb.sv
// Self-checking testbench for cluster_chain_table_engine_unit: a directed run and then random
// operation sequences, checked against a link-table predictor updated at each input transfer.
// Depends on ccte_pkg and the engine RTL only.
`timescale 1ns / 1ps

module cluster_chain_table_engine_unit_tb;

    import ccte_pkg::*;

    localparam int NUM_CLUSTERS = 128;
    localparam int TBL          = (NUM_CLUSTERS < 128) ? NUM_CLUSTERS : 128;
    localparam int N_RANDOM     = 450;
    localparam int IDLE_PCT     = 21;
    localparam int HOLD_CYCLES  = 1000;
    localparam int DRAIN_CYCLES = 300;
    localparam int QUIET_LIMIT  = 100000;

    // Opcode that the engine does not define; it must do nothing.
    localparam logic [OPW-1:0] OP_RESERVED = 3'd7;

    logic      i_clk     = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    cluster_chain_table_engine_unit #(
        .NUM_CLUSTERS(NUM_CLUSTERS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    wire in_fire  = in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !out_stall;

    // Operations waiting to be offered, and results still owed by the engine.
    t_in_item  op_queue[$];
    t_out_item expected_results[$];

    // Shadow copy of the file-allocation table.
    logic [CW-1:0] fat_link [0:127];

    int n_err = 0;
    int n_acc = 0;
    int n_ret = 0;

    function automatic logic [CW-1:0] link_rd(input int c);
        return (c < TBL) ? fat_link[c] : '0;
    endfunction

    function automatic void link_wr(input int c, input logic [CW-1:0] v);
        if (c < TBL) begin
            fat_link[c] = v;
        end
    endfunction

    // Lowest free cluster above the reserved one, zero when the table is full.
    function automatic logic [CW-1:0] find_lowest_free();
        int i;
        for (i = 1; i < TBL; i++) begin
            if (fat_link[i] == '0) begin
                return CW'(i);
            end
        end
        return '0;
    endfunction

    // Follow one link, growing the chain by the lowest free cluster at its end.
    function automatic logic [CW-1:0] follow_link(input logic [CW-1:0] c,
                                                  output logic [STW-1:0] st);
        logic [CW-1:0] t;
        logic [CW-1:0] f;
        st = ST_OK;
        if (int'(c) >= TBL) begin
            st = ST_NOT_USED;
            return '0;
        end
        t = link_rd(c);
        if (t == c) begin
            f = find_lowest_free();
            if (f == '0) begin
                st = ST_NO_FREE;
                return '0;
            end
            link_wr(c, f);
            link_wr(f, f);
            return f;
        end
        if (t == '0) begin
            st = ST_NOT_USED;
            return '0;
        end
        return t;
    endfunction

    // Apply one operation to the shadow table and return the result it should produce.
    function automatic t_out_item predict_table_op(input t_in_item it);
        t_out_item     o;
        logic [CW-1:0] n;
        logic [CW-1:0] u;
        logic [CW-1:0] nx;
        logic [STW-1:0] st;
        int i;
        o = '0;
        case (it.opcode)
            OP_CLEAR: begin
                for (i = 0; i < 128; i++) begin
                    fat_link[i] = '0;
                end
            end
            OP_ALLOC: begin
                o.result_cluster = find_lowest_free();
                if (o.result_cluster == '0) begin
                    o.status = ST_NO_FREE;
                end else begin
                    link_wr(o.result_cluster, o.result_cluster);
                end
            end
            OP_NEXT: begin
                o.result_cluster = follow_link(it.cluster, st);
                o.status = st;
            end
            OP_HOP: begin
                o.result_cluster = it.cluster;
                for (i = 0; i < int'(it.hops); i++) begin
                    o.result_cluster = follow_link(o.result_cluster, st);
                    o.status = st;
                    if (o.result_cluster == '0) begin
                        break;
                    end
                end
            end
            OP_FREE: begin
                n = it.cluster;
                for (i = 0; i < TBL && n != '0; i++) begin
                    u = n;
                    nx = link_rd(u);
                    n = (nx == u) ? '0 : nx;
                    link_wr(u, '0);
                end
            end
            OP_UNLINK: begin
                nx = link_rd(it.cluster);
                if (nx == '0) begin
                    o.status = ST_NOT_USED;
                end else begin
                    // Predecessors skip the cluster; if it ended the chain they end it instead.
                    for (i = 0; i < TBL; i++) begin
                        if (fat_link[i] == it.cluster) begin
                            fat_link[i] = (nx == it.cluster) ? CW'(i) : nx;
                        end
                    end
                    link_wr(it.cluster, '0);
                end
            end
            OP_COUNT: begin
                for (i = 1; i < TBL; i++) begin
                    if (fat_link[i] == '0) begin
                        o.free_count = o.free_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    function automatic void queue_op(input logic [OPW-1:0] op, input int c, input int h);
        t_in_item it;
        it.opcode  = op;
        it.cluster = CW'(c);
        it.hops    = HW'(h);
        op_queue.push_back(it);
    endfunction

    // A cluster that is currently in use, if one turns up quickly.
    function automatic int pick_used();
        int k;
        int c;
        for (k = 0; k < 24; k++) begin
            c = $urandom_range(1, TBL - 1);
            if (fat_link[c] != '0) begin
                return c;
            end
        end
        return $urandom_range(0, 127);
    endfunction

    function automatic int pick_hops();
        if ($urandom_range(59) == 0) begin
            return $urandom_range(0, 255);
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(0, 40);
        end
        return $urandom_range(0, 6);
    endfunction

    // Mostly meaningful operations on live chains, with some noise mixed in.
    function automatic void queue_random_op();
        int r;
        r = $urandom_range(99);
        if (r < 20) begin
            queue_op(OP_ALLOC, $urandom_range(0, 127), $urandom_range(0, 255));
        end else if (r < 40) begin
            queue_op(OP_NEXT, pick_used(), $urandom_range(0, 255));
        end else if (r < 55) begin
            queue_op(OP_HOP, pick_used(), pick_hops());
        end else if (r < 67) begin
            queue_op(OP_FREE, pick_used(), $urandom_range(0, 255));
        end else if (r < 77) begin
            queue_op(OP_UNLINK, pick_used(), $urandom_range(0, 255));
        end else if (r < 85) begin
            queue_op(OP_COUNT, $urandom_range(0, 127), $urandom_range(0, 255));
        end else if (r < 88) begin
            queue_op(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 255));
        end else begin
            queue_op(OPW'($urandom_range(0, 7)), $urandom_range(0, 127), pick_hops());
        end
    endfunction

    // Sender: offers queued operations and updates the prediction at each transfer.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                expected_results.push_back(predict_table_op(op_queue.pop_front()));
                n_acc++;
            end
            if (in_valid && o_in_stall) begin
                in_valid <= 1'b1;
            end else if (op_queue.size() != 0 &&
                         ((n_acc >= 120 && n_acc < 200) ||
                          $urandom_range(99) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                in_item  <= op_queue[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each returned result and applies stalls, with one long hold-off.
    int  hold_cnt  = 0;
    bit  hold_done = 1'b0;
    t_out_item want;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_fire) begin
                n_ret++;
                if (expected_results.size() == 0) begin
                    n_err++;
                    $error("result with no operation outstanding: %p", o_out_item);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_item.result_cluster !== want.result_cluster) begin
                        n_err++;
                        $error("result_cluster: expected %0d, got %0d",
                               want.result_cluster, o_out_item.result_cluster);
                    end
                    if (o_out_item.status !== want.status) begin
                        n_err++;
                        $error("status: expected %0d, got %0d",
                               want.status, o_out_item.status);
                    end
                    if (o_out_item.free_count !== want.free_count) begin
                        n_err++;
                        $error("free_count: expected %0d, got %0d",
                               want.free_count, o_out_item.free_count);
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt  <= hold_cnt - 1;
                out_stall <= 1'b1;
            end else if (!hold_done && n_ret >= 60) begin
                hold_done <= 1'b1;
                hold_cnt  <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (n_ret >= 120 && n_ret < 200) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int quiet = 0;

    always @(posedge i_clk) begin
        if (!rst_n || in_fire || out_fire) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("FAIL cluster_chain_table_engine_unit");
            $finish;
        end
    end

    // Stimulus: directed cases, then random batches built from the current table.
    int n_gen;
    int batch;
    int j;

    initial begin
        for (j = 0; j < 128; j++) begin
            fat_link[j] = '0;
        end

        // Empty table, directory chain grown from cluster zero, walks, unlinks and frees.
        queue_op(OP_COUNT, 0, 0);
        queue_op(OP_NEXT, 0, 0);
        queue_op(OP_NEXT, 5, 0);
        queue_op(OP_ALLOC, 0, 0);
        queue_op(OP_HOP, 2, 0);
        queue_op(OP_HOP, 2, 3);
        queue_op(OP_NEXT, 2, 0);
        queue_op(OP_UNLINK, 4, 0);
        queue_op(OP_UNLINK, 5, 0);
        queue_op(OP_UNLINK, 9, 0);
        queue_op(OP_FREE, 0, 0);
        queue_op(OP_FREE, 2, 0);
        queue_op(OP_FREE, 50, 0);
        queue_op(OP_COUNT, 0, 0);
        queue_op(OP_RESERVED, 127, 255);
        queue_op(OP_HOP, 127, 255);
        queue_op(OP_CLEAR, 0, 0);
        // Fill the whole table from cluster zero, then hit the full-table cases.
        queue_op(OP_HOP, 0, 128);
        queue_op(OP_ALLOC, 0, 0);
        queue_op(OP_NEXT, 127, 0);
        queue_op(OP_COUNT, 0, 0);
        queue_op(OP_UNLINK, 0, 0);
        queue_op(OP_FREE, 1, 0);
        queue_op(OP_COUNT, 127, 255);
        queue_op(OP_CLEAR, 0, 0);

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        n_gen = 0;
        while (n_gen < N_RANDOM) begin
            // Batches are built once all earlier operations have reached the predictor.
            while (op_queue.size() != 0) @(negedge i_clk);
            batch = $urandom_range(4, 12);
            for (j = 0; j < batch; j++) begin
                queue_random_op();
                n_gen++;
                if (n_gen == 200) begin
                    while (op_queue.size() != 0 || expected_results.size() != 0) begin
                        @(negedge i_clk);
                    end
                    repeat (20) @(negedge i_clk);
                end
            end
        end

        while (op_queue.size() != 0 || expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_err == 0) begin
            $display("PASS cluster_chain_table_engine_unit");
        end else begin
            $display("FAIL cluster_chain_table_engine_unit");
        end
        $finish;
    end

endmodule
